// ----- hw/rtl/dexs_pkg.sv -----
// ----------------------------------------------------------------------------
// dexs_pkg
// Shared constants, command codes and stage types for the determinant
// excitation sign core.
// ----------------------------------------------------------------------------
package dexs_pkg;

    // orbitals per spin, 2..64
    localparam int ORBITALS = 64;

    // fixed field widths
    localparam int STR_W = 64;
    localparam int IDX_W = 6;
    localparam int CMD_W = 4;
    localparam int PH_W  = 2;

    // range bounds run one past the top index
    localparam int BND_W  = IDX_W + 1;
    localparam int CHUNKS = STR_W / 8;

    // valid orbital bits of a string
    localparam logic [STR_W-1:0] ORB_MASK =
        (ORBITALS >= STR_W) ? {STR_W{1'b1}}
                            : ((STR_W'(1) << ORBITALS) - STR_W'(1));
    localparam logic [BND_W-1:0] ORB_LIMIT = BND_W'(ORBITALS);

    // phase codes
    localparam logic signed [PH_W-1:0] PHASE_ZERO = 2'sb00;
    localparam logic signed [PH_W-1:0] PHASE_POS  = 2'sb01;
    localparam logic signed [PH_W-1:0] PHASE_NEG  = 2'sb11;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE_A  = 4'd0,
        CMD_CREATE_B  = 4'd1,
        CMD_DESTROY_A = 4'd2,
        CMD_DESTROY_B = 4'd3,
        CMD_SINGLE_A  = 4'd4,
        CMD_SINGLE_B  = 4'd5,
        CMD_DOUBLE_AA = 4'd6,
        CMD_DOUBLE_AB = 4'd7,
        CMD_DOUBLE_BB = 4'd8
    } cmd_t;

    // half-open orbital range [lo, hi) whose parity is taken
    typedef struct packed {
        logic [BND_W-1:0] lo;
        logic [BND_W-1:0] hi;
    } range_t;

    // pair selection of the four-index rule
    typedef struct packed {
        range_t r1;
        range_t r2;
        logic   neg;
    } four_t;

    // after update and decode
    typedef struct packed {
        logic [STR_W-1:0] alpha;
        logic [STR_W-1:0] beta;
        logic             zero;
        logic             neg;
        range_t           r1;
        range_t           r2;
        logic             sel1_beta;
        logic             sel2_beta;
    } stage1_t;

    // after masking and chunk parity
    typedef struct packed {
        logic [STR_W-1:0]  alpha;
        logic [STR_W-1:0]  beta;
        logic              zero;
        logic              neg;
        logic [CHUNKS-1:0] par1;
        logic [CHUNKS-1:0] par2;
    } stage2_t;

endpackage

// ----- hw/rtl/dexs_in_if.sv -----
// ----------------------------------------------------------------------------
// dexs_in_if
// Operand channel: command, occupation strings and orbital indices.
// ----------------------------------------------------------------------------
interface dexs_in_if;
    import dexs_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [STR_W-1:0] alpha_in;
    logic [STR_W-1:0] beta_in;
    logic [IDX_W-1:0] hole_first;
    logic [IDX_W-1:0] hole_second;
    logic [IDX_W-1:0] particle_first;
    logic [IDX_W-1:0] particle_second;

    modport source (
        output valid, command, alpha_in, beta_in,
               hole_first, hole_second, particle_first, particle_second,
        input  ready
    );

    modport sink (
        input  valid, command, alpha_in, beta_in,
               hole_first, hole_second, particle_first, particle_second,
        output ready
    );
endinterface

// ----- hw/rtl/dexs_out_if.sv -----
// ----------------------------------------------------------------------------
// dexs_out_if
// Result channel: updated occupation strings and fermionic phase.
// ----------------------------------------------------------------------------
interface dexs_out_if;
    import dexs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STR_W-1:0]       alpha_out;
    logic [STR_W-1:0]       beta_out;
    logic signed [PH_W-1:0] phase;

    modport source (
        output valid, alpha_out, beta_out, phase,
        input  ready
    );

    modport sink (
        input  valid, alpha_out, beta_out, phase,
        output ready
    );
endinterface

// ----- hw/rtl/determinant_excitation_sign_core.sv -----
// ----------------------------------------------------------------------------
// determinant_excitation_sign_core
// Applies a create, destroy, single or double excitation operator to an
// alpha/beta occupation string pair and returns the new strings with the
// fermionic phase (-1, 0, +1).
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  operand   in    valid/ready    command, alpha_in, beta_in, hole_first,
//                                 hole_second, particle_first, particle_second
//  result    out   valid/ready    alpha_out, beta_out, phase
//
//  one beat per cycle in, one per cycle out while the pipe is not held
//  stage 1: decode, index checks and string update; stage 2: range masks and
//  byte parities; stage 3: parity fold and phase into the output register
//  the three stages advance together; when a result waits and result.ready
//  is low the whole pipe holds and operand.ready drops
//  reset clears the stage valid bits only
//
module determinant_excitation_sign_core (
    input  logic              clk,
    input  logic              rst_n,
    dexs_in_if.sink           operand,
    dexs_out_if.source        result
);
    import dexs_pkg::*;

    // parity range [min+1, max) strictly between two indices
    function automatic range_t between(input logic [IDX_W-1:0] p,
                                       input logic [IDX_W-1:0] q);
        range_t r;
        if (p < q)
        begin
            r.lo = {1'b0, p} + BND_W'(1);
            r.hi = {1'b0, q};
        end
        else
        begin
            r.lo = {1'b0, q} + BND_W'(1);
            r.hi = {1'b0, p};
        end
        return r;
    endfunction

    // same-spin double pairing rule
    function automatic four_t pick_four(input logic [IDX_W-1:0] i,
                                        input logic [IDX_W-1:0] j,
                                        input logic [IDX_W-1:0] a,
                                        input logic [IDX_W-1:0] b);
        four_t f;
        logic  all_below;
        logic  none_below;
        logic  flip;
        all_below  = (i < a) && (j < a) && (i < b) && (j < b);
        none_below = !((i < a) || (j < a) || (i < b) || (j < b));
        flip       = (i < j) != (a < b);
        if (all_below || none_below)
        begin
            f.r1  = between(i, j);
            f.r2  = between(a, b);
            f.neg = flip;
        end
        else if (flip)
        begin
            f.r1  = between(i, b);
            f.r2  = between(j, a);
            f.neg = 1'b1;
        end
        else
        begin
            f.r1  = between(i, a);
            f.r2  = between(j, b);
            f.neg = 1'b0;
        end
        return f;
    endfunction

    // bit k set when lo <= k < hi
    function automatic logic [STR_W-1:0] range_mask(input range_t r);
        logic [STR_W-1:0] m;
        for (int k = 0; k < STR_W; k++)
        begin
            m[k] = (BND_W'(k) >= r.lo) && (BND_W'(k) < r.hi);
        end
        return m;
    endfunction

    // parity of each byte
    function automatic logic [CHUNKS-1:0] byte_parity(input logic [STR_W-1:0] x);
        logic [CHUNKS-1:0] p;
        for (int c = 0; c < CHUNKS; c++)
        begin
            p[c] = ^x[c*8 +: 8];
        end
        return p;
    endfunction

    logic                   advance;
    logic                   s1_valid_reg;
    logic                   s2_valid_reg;
    logic                   out_valid_reg;
    stage1_t                s1_next;
    stage1_t                s1_reg;
    stage2_t                s2_next;
    stage2_t                s2_reg;
    logic [STR_W-1:0]       out_alpha_reg;
    logic [STR_W-1:0]       out_beta_reg;
    logic signed [PH_W-1:0] out_phase_reg;
    logic signed [PH_W-1:0] phase_next;

    // whole pipe moves unless a result is held
    assign advance       = !out_valid_reg || result.ready;
    assign operand.ready = advance;

    // stage 1: decode, range checks and string update
    logic [STR_W-1:0] al0;
    logic [STR_W-1:0] be0;
    logic [STR_W-1:0] oh_i;
    logic [STR_W-1:0] oh_j;
    logic [STR_W-1:0] oh_a;
    logic [STR_W-1:0] oh_b;
    logic             ok_i;
    logic             ok_ia;
    logic             ok_all;
    four_t            four;

    always_comb
    begin
        al0    = operand.alpha_in & ORB_MASK;
        be0    = operand.beta_in & ORB_MASK;
        oh_i   = STR_W'(1) << operand.hole_first;
        oh_j   = STR_W'(1) << operand.hole_second;
        oh_a   = STR_W'(1) << operand.particle_first;
        oh_b   = STR_W'(1) << operand.particle_second;
        ok_i   = {1'b0, operand.hole_first} < ORB_LIMIT;
        ok_ia  = ok_i && ({1'b0, operand.particle_first} < ORB_LIMIT);
        ok_all = ok_ia && ({1'b0, operand.hole_second} < ORB_LIMIT)
                       && ({1'b0, operand.particle_second} < ORB_LIMIT);
        four   = pick_four(operand.hole_first, operand.hole_second,
                           operand.particle_first, operand.particle_second);

        s1_next.alpha     = al0;
        s1_next.beta      = be0;
        s1_next.zero      = 1'b1;
        s1_next.neg       = 1'b0;
        s1_next.r1        = '0;
        s1_next.r2        = '0;
        s1_next.sel1_beta = 1'b0;
        s1_next.sel2_beta = 1'b0;

        unique case (cmd_t'(operand.command))
            CMD_CREATE_A:
            begin
                if (ok_i && ((al0 & oh_i) == '0))
                begin
                    s1_next.alpha = al0 | oh_i;
                    s1_next.zero  = 1'b0;
                    s1_next.r1.hi = {1'b0, operand.hole_first};
                end
            end
            CMD_CREATE_B:
            begin
                if (ok_i && ((be0 & oh_i) == '0))
                begin
                    s1_next.beta      = be0 | oh_i;
                    s1_next.zero      = 1'b0;
                    s1_next.r1.hi     = {1'b0, operand.hole_first};
                    s1_next.sel1_beta = 1'b1;
                end
            end
            CMD_DESTROY_A:
            begin
                if (ok_i && ((al0 & oh_i) != '0))
                begin
                    s1_next.alpha = al0 & ~oh_i;
                    s1_next.zero  = 1'b0;
                    s1_next.r1.hi = {1'b0, operand.hole_first};
                end
            end
            CMD_DESTROY_B:
            begin
                if (ok_i && ((be0 & oh_i) != '0))
                begin
                    s1_next.beta      = be0 & ~oh_i;
                    s1_next.zero      = 1'b0;
                    s1_next.r1.hi     = {1'b0, operand.hole_first};
                    s1_next.sel1_beta = 1'b1;
                end
            end
            CMD_SINGLE_A:
            begin
                if (ok_ia)
                begin
                    s1_next.alpha = (al0 & ~oh_i) | oh_a;
                    s1_next.zero  = 1'b0;
                    s1_next.r1    = between(operand.hole_first, operand.particle_first);
                end
            end
            CMD_SINGLE_B:
            begin
                if (ok_ia)
                begin
                    s1_next.beta      = (be0 & ~oh_i) | oh_a;
                    s1_next.zero      = 1'b0;
                    s1_next.r1        = between(operand.hole_first,
                                                operand.particle_first);
                    s1_next.sel1_beta = 1'b1;
                end
            end
            CMD_DOUBLE_AA:
            begin
                if (ok_all)
                begin
                    s1_next.alpha = (al0 & ~oh_i & ~oh_j) | oh_b | oh_a;
                    s1_next.zero  = 1'b0;
                    s1_next.r1    = four.r1;
                    s1_next.r2    = four.r2;
                    s1_next.neg   = four.neg;
                end
            end
            CMD_DOUBLE_AB:
            begin
                if (ok_all)
                begin
                    s1_next.alpha     = (al0 & ~oh_i) | oh_a;
                    s1_next.beta      = (be0 & ~oh_j) | oh_b;
                    s1_next.zero      = 1'b0;
                    s1_next.r1        = between(operand.hole_first,
                                                operand.particle_first);
                    s1_next.r2        = between(operand.hole_second,
                                                operand.particle_second);
                    s1_next.sel2_beta = 1'b1;
                end
            end
            CMD_DOUBLE_BB:
            begin
                if (ok_all)
                begin
                    s1_next.beta      = (be0 & ~oh_i & ~oh_j) | oh_b | oh_a;
                    s1_next.zero      = 1'b0;
                    s1_next.r1        = four.r1;
                    s1_next.r2        = four.r2;
                    s1_next.neg       = four.neg;
                    s1_next.sel1_beta = 1'b1;
                    s1_next.sel2_beta = 1'b1;
                end
            end
            default:
            begin
                s1_next.zero = 1'b1;
            end
        endcase
    end

    // stage 2: mask the chosen strings and fold each byte
    logic [STR_W-1:0] str1;
    logic [STR_W-1:0] str2;

    always_comb
    begin
        str1          = s1_reg.sel1_beta ? s1_reg.beta : s1_reg.alpha;
        str2          = s1_reg.sel2_beta ? s1_reg.beta : s1_reg.alpha;
        s2_next.alpha = s1_reg.alpha;
        s2_next.beta  = s1_reg.beta;
        s2_next.zero  = s1_reg.zero;
        s2_next.neg   = s1_reg.neg;
        s2_next.par1  = byte_parity(str1 & range_mask(s1_reg.r1));
        s2_next.par2  = byte_parity(str2 & range_mask(s1_reg.r2));
    end

    // stage 3: fold byte parities into the phase
    always_comb
    begin
        if (s2_reg.zero)
        begin
            phase_next = PHASE_ZERO;
        end
        else if ((^s2_reg.par1) ^ (^s2_reg.par2) ^ s2_reg.neg)
        begin
            phase_next = PHASE_NEG;
        end
        else
        begin
            phase_next = PHASE_POS;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= operand.valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            out_alpha_reg <= s2_reg.alpha;
            out_beta_reg  <= s2_reg.beta;
            out_phase_reg <= phase_next;
        end
    end

    // result beat
    assign result.valid     = out_valid_reg;
    assign result.alpha_out = out_alpha_reg;
    assign result.beta_out  = out_beta_reg;
    assign result.phase     = out_phase_reg;

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for determinant_excitation_sign_core. A stream of
// operator beats (directed corner cases, then random determinants and
// indices) goes through the operand channel. Each accepted beat is scored
// by an in-bench predictor of the fermionic phase and the updated strings.
// Result beats are compared in order with the predictions. Both channels
// stall at random in the first two of three traffic phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dexs_pkg::*;

    localparam int RANDOM_OPS   = 1930;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [CMD_W-1:0] command;
        logic [STR_W-1:0] alpha;
        logic [STR_W-1:0] beta;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
    } op_beat_t;

    typedef struct {
        logic [STR_W-1:0]       alpha;
        logic [STR_W-1:0]       beta;
        logic signed [PH_W-1:0] phase;
    } det_sign_t;

    logic clk;
    logic rst_n;

    dexs_in_if  operand_bus ();
    dexs_out_if result_bus ();

    op_beat_t  pending_ops[$];
    det_sign_t expected_signs[$];
    op_beat_t  next_op;
    det_sign_t want;

    int  total_ops;
    int  accepted_ops;
    int  err_cnt;
    int  quiet_cycles;
    bit  op_taken;
    bit  res_taken;

    determinant_excitation_sign_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_bus),
        .result  (result_bus)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // bits 0..k-1 set
    function automatic logic [STR_W-1:0] low_bits(int k);
        if (k >= STR_W)
            return '1;
        return (STR_W'(1) << k) - STR_W'(1);
    endfunction

    function automatic logic [STR_W-1:0] orb_bit(logic [IDX_W-1:0] k);
        return STR_W'(1) << k;
    endfunction

    // odd count of occupied orbitals strictly between p and q
    function automatic bit odd_between(logic [STR_W-1:0] s, int p, int q);
        int lo;
        int hi;
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        if (hi - lo < 2)
            return 1'b0;
        return ^(s & low_bits(hi) & ~low_bits(lo + 1));
    endfunction

    // same-spin double: pairing picked by index ordering
    function automatic bit odd_four(logic [STR_W-1:0] s, int i, int j, int a, int b);
        bit all_low;
        bit none_low;
        bit flip;
        all_low  = (i < a) && (j < a) && (i < b) && (j < b);
        none_low = !((i < a) || (j < a) || (i < b) || (j < b));
        flip     = (i < j) != (a < b);
        if (all_low || none_low)
            return odd_between(s, i, j) ^ odd_between(s, a, b) ^ flip;
        if (flip)
            return 1'b1 ^ odd_between(s, i, b) ^ odd_between(s, j, a);
        return odd_between(s, i, a) ^ odd_between(s, j, b);
    endfunction

    function automatic det_sign_t apply_operator(op_beat_t op);
        det_sign_t r;
        bit        in_range;
        bit        zero;
        bit        odd;
        r.alpha  = op.alpha & ORB_MASK;
        r.beta   = op.beta & ORB_MASK;
        zero     = 1'b1;
        odd      = 1'b0;
        if (op.command <= CMD_DESTROY_B)
            in_range = op.i < ORBITALS;
        else if (op.command <= CMD_SINGLE_B)
            in_range = (op.i < ORBITALS) && (op.a < ORBITALS);
        else
            in_range = (op.i < ORBITALS) && (op.j < ORBITALS)
                    && (op.a < ORBITALS) && (op.b < ORBITALS);
        if (in_range)
        begin
            case (op.command)
                CMD_CREATE_A:
                    if (!r.alpha[op.i])
                    begin
                        r.alpha[op.i] = 1'b1;
                        zero = 1'b0;
                        odd  = ^(r.alpha & low_bits(op.i));
                    end
                CMD_CREATE_B:
                    if (!r.beta[op.i])
                    begin
                        r.beta[op.i] = 1'b1;
                        zero = 1'b0;
                        odd  = ^(r.beta & low_bits(op.i));
                    end
                CMD_DESTROY_A:
                    if (r.alpha[op.i])
                    begin
                        r.alpha[op.i] = 1'b0;
                        zero = 1'b0;
                        odd  = ^(r.alpha & low_bits(op.i));
                    end
                CMD_DESTROY_B:
                    if (r.beta[op.i])
                    begin
                        r.beta[op.i] = 1'b0;
                        zero = 1'b0;
                        odd  = ^(r.beta & low_bits(op.i));
                    end
                CMD_SINGLE_A:
                begin
                    r.alpha = (r.alpha & ~orb_bit(op.i)) | orb_bit(op.a);
                    zero = 1'b0;
                    odd  = odd_between(r.alpha, op.i, op.a);
                end
                CMD_SINGLE_B:
                begin
                    r.beta = (r.beta & ~orb_bit(op.i)) | orb_bit(op.a);
                    zero = 1'b0;
                    odd  = odd_between(r.beta, op.i, op.a);
                end
                CMD_DOUBLE_AA:
                begin
                    r.alpha = r.alpha & ~orb_bit(op.i) & ~orb_bit(op.j);
                    r.alpha = r.alpha | orb_bit(op.b) | orb_bit(op.a);
                    zero = 1'b0;
                    odd  = odd_four(r.alpha, op.i, op.j, op.a, op.b);
                end
                CMD_DOUBLE_AB:
                begin
                    r.alpha = (r.alpha & ~orb_bit(op.i)) | orb_bit(op.a);
                    r.beta  = (r.beta & ~orb_bit(op.j)) | orb_bit(op.b);
                    zero = 1'b0;
                    odd  = odd_between(r.alpha, op.i, op.a)
                         ^ odd_between(r.beta, op.j, op.b);
                end
                CMD_DOUBLE_BB:
                begin
                    r.beta = r.beta & ~orb_bit(op.i) & ~orb_bit(op.j);
                    r.beta = r.beta | orb_bit(op.b) | orb_bit(op.a);
                    zero = 1'b0;
                    odd  = odd_four(r.beta, op.i, op.j, op.a, op.b);
                end
                default:
                    zero = 1'b1;
            endcase
        end
        r.phase = zero ? PHASE_ZERO : (odd ? PHASE_NEG : PHASE_POS);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_op(logic [CMD_W-1:0] cmd, logic [STR_W-1:0] al,
                          logic [STR_W-1:0] be, int i, int j, int a, int b);
        op_beat_t op;
        op.command = cmd;
        op.alpha   = al;
        op.beta    = be;
        op.i       = IDX_W'(i);
        op.j       = IDX_W'(j);
        op.a       = IDX_W'(a);
        op.b       = IDX_W'(b);
        pending_ops = {pending_ops, op};
    endtask

    // random occupation string of varied density
    function automatic logic [STR_W-1:0] rand_occupation();
        case ($urandom_range(4))
            0: return {$urandom, $urandom} & {$urandom, $urandom}
                      & {$urandom, $urandom};
            1: return {$urandom, $urandom} | {$urandom, $urandom}
                      | {$urandom, $urandom};
            2: return {STR_W{1'($urandom_range(1))}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // orbital index, biased toward the ends
    function automatic int rand_orbital();
        case ($urandom_range(9))
            0: return 0;
            1: return 63;
            2: return $urandom_range(1) ? 1 : 62;
            default: return $urandom_range(63);
        endcase
    endfunction

    // idle percentage of each side, by traffic phase
    function automatic int idle_pct(bit rx_side);
        if (accepted_ops < total_ops / 3)
            return rx_side ? 80 : 34;
        if (accepted_ops < (2 * total_ops) / 3)
            return rx_side ? 34 : 80;
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CMD_W-1:0] cmd;
        logic [STR_W-1:0] al;
        logic [STR_W-1:0] be;
        int               i;
        int               j;
        int               a;
        int               b;

        // known levels from time zero
        rst_n                       = 1'b0;
        operand_bus.valid           = 1'b0;
        operand_bus.command         = '0;
        operand_bus.alpha_in        = '0;
        operand_bus.beta_in         = '0;
        operand_bus.hole_first      = '0;
        operand_bus.hole_second     = '0;
        operand_bus.particle_first  = '0;
        operand_bus.particle_second = '0;
        result_bus.ready            = 1'b0;
        err_cnt                     = 0;
        accepted_ops                = 0;
        quiet_cycles                = 0;
        op_taken                    = 1'b0;
        res_taken                   = 1'b0;

        // directed: create and destroy at both ends, occupied and empty
        add_op(CMD_CREATE_A,  '0, '0, 0, 0, 0, 0);
        add_op(CMD_CREATE_A,  '1, '0, 63, 0, 0, 0);
        add_op(CMD_CREATE_B,  '1, '0, 63, 0, 0, 0);
        add_op(CMD_CREATE_B,  '0, '1, 0, 0, 0, 0);
        add_op(CMD_DESTROY_A, '1, '0, 63, 0, 0, 0);
        add_op(CMD_DESTROY_A, '0, '1, 0, 0, 0, 0);
        add_op(CMD_DESTROY_B, '0, '1, 0, 0, 0, 0);
        add_op(CMD_DESTROY_B, '1, '0, 63, 0, 0, 0);
        add_op(CMD_DESTROY_A, {32{2'b10}}, '0, 33, 0, 0, 0);
        // singles: full span, repeated index, adjacent orbitals
        add_op(CMD_SINGLE_A, '1, '0, 0, 0, 63, 0);
        add_op(CMD_SINGLE_A, {32{2'b01}}, '1, 5, 0, 5, 0);
        add_op(CMD_SINGLE_B, '0, {32{2'b10}}, 63, 0, 0, 0);
        add_op(CMD_SINGLE_B, '1, '1, 10, 0, 11, 0);
        // same-spin doubles across each ordering case
        add_op(CMD_DOUBLE_AA, '1, '0, 0, 63, 1, 62);
        add_op(CMD_DOUBLE_AA, {32{2'b10}}, '0, 1, 2, 40, 50);
        add_op(CMD_DOUBLE_AA, {32{2'b01}}, '1, 50, 40, 2, 1);
        add_op(CMD_DOUBLE_AA, '1, '1, 7, 7, 7, 7);
        add_op(CMD_DOUBLE_BB, '0, {32{2'b01}}, 5, 30, 20, 40);
        add_op(CMD_DOUBLE_BB, '0, '1, 63, 0, 0, 63);
        add_op(CMD_DOUBLE_BB, '1, {32{2'b10}}, 2, 1, 50, 40);
        // mixed-spin double with extreme indices
        add_op(CMD_DOUBLE_AB, '1, '0, 0, 63, 63, 0);
        add_op(CMD_DOUBLE_AB, {32{2'b10}}, {32{2'b01}}, 63, 0, 0, 63);
        // unknown commands pass strings through
        add_op(CMD_W'(9), '1, {32{2'b01}}, 3, 4, 5, 6);
        add_op(CMD_W'(15), {32{2'b10}}, '1, 63, 63, 63, 63);

        // random operators, a few unknown commands mixed in
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if ($urandom_range(99) < 5)
                cmd = CMD_W'($urandom_range(15, 9));
            else
                cmd = CMD_W'($urandom_range(8));
            al = rand_occupation();
            be = rand_occupation();
            i  = rand_orbital();
            j  = rand_orbital();
            a  = rand_orbital();
            b  = rand_orbital();
            // repeated indices now and then
            if ($urandom_range(9) == 0)
                j = i;
            if ($urandom_range(9) == 0)
                b = a;
            if ($urandom_range(19) == 0)
                a = i;
            // steer create/destroy targets to occupied or empty
            if ($urandom_range(1))
            begin
                al[i] = 1'($urandom_range(1));
                be[i] = 1'($urandom_range(1));
            end
            add_op(cmd, al, be, i, j, a, b);
        end
        total_ops = pending_ops.size();

        // hold reset low, then release it on a falling edge
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // drain
        while (pending_ops.size() != 0 || operand_bus.valid
               || expected_signs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // operand driver: holds a beat until taken, then offers the next
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            operand_bus.valid <= 1'b0;
        else if (!operand_bus.valid || op_taken)
        begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct(1'b0))
            begin
                next_op = pending_ops.pop_front();
                operand_bus.valid           <= 1'b1;
                operand_bus.command         <= next_op.command;
                operand_bus.alpha_in        <= next_op.alpha;
                operand_bus.beta_in         <= next_op.beta;
                operand_bus.hole_first      <= next_op.i;
                operand_bus.hole_second     <= next_op.j;
                operand_bus.particle_first  <= next_op.a;
                operand_bus.particle_second <= next_op.b;
            end
            else
                operand_bus.valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
            result_bus.ready <= ($urandom_range(99) >= idle_pct(1'b1));
    end

    // ------------------------------------------------------------------------
    // operand monitor: predict each accepted beat
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        op_beat_t seen;
        op_taken = rst_n && operand_bus.valid && operand_bus.ready;
        if (op_taken)
        begin
            seen.command = operand_bus.command;
            seen.alpha   = operand_bus.alpha_in;
            seen.beta    = operand_bus.beta_in;
            seen.i       = operand_bus.hole_first;
            seen.j       = operand_bus.hole_second;
            seen.a       = operand_bus.particle_first;
            seen.b       = operand_bus.particle_second;
            expected_signs = {expected_signs, apply_operator(seen)};
            accepted_ops++;
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: compare with oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_taken = rst_n && result_bus.valid && result_bus.ready;
        if (res_taken)
        begin
            if (expected_signs.size() == 0)
            begin
                $error("result beat with no prediction pending");
                err_cnt++;
            end
            else
            begin
                want = expected_signs.pop_front();
                if (result_bus.alpha_out !== want.alpha)
                begin
                    $error("alpha_out: expected %h, got %h", want.alpha,
                           result_bus.alpha_out);
                    err_cnt++;
                end
                if (result_bus.beta_out !== want.beta)
                begin
                    $error("beta_out: expected %h, got %h", want.beta,
                           result_bus.beta_out);
                    err_cnt++;
                end
                if (result_bus.phase !== want.phase)
                begin
                    $error("phase: expected %0d, got %0d", want.phase,
                           result_bus.phase);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((rst_n && operand_bus.valid && operand_bus.ready)
            || (rst_n && result_bus.valid && result_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("no beat for %0d cycles", STALL_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

endmodule
